// ===== rtl/bb3_pkg.sv =====
package bb3_pkg;

  localparam int CH_W       = 8;
  localparam int PX_W       = 3 * CH_W;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CMD_DEPTH  = 4;
  localparam int OUT_DEPTH  = 4;
  localparam int OCC_W      = $clog2(OUT_DEPTH + 1) + 1;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } out_item_t;

  typedef struct packed {
    logic            is_flush;
    logic [PX_W-1:0] px;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [CNT_W-1:0] cnt;
    logic             frame_end;
  } sum_t;

endpackage

// ===== rtl/bb3_ram.sv =====
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bb3_fifo.sv =====
module bb3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/bb3_front.sv =====
module bb3_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  bb3_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic              cmd_pop,
  output bb3_pkg::cmd_t     cmd,
  output logic              cmd_empty
);
  import bb3_pkg::*;

  cmd_t                           cmd_in;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  // classify the beat: flush ticks carry a black pixel
  always_comb begin
    cmd_in.is_flush = (in_item.kind == KIND_FLUSH);
    cmd_in.px       = cmd_in.is_flush ? '0 :
                      {in_item.in_red, in_item.in_green, in_item.in_blue};
  end

  bb3_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (cmd_in),
    .pop       (cmd_pop),
    .pop_data  (cmd),
    .full      (in_full),
    .empty     (cmd_empty),
    .count     (cmd_count)
  );

endmodule

// ===== rtl/bb3_back.sv =====
module bb3_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  bb3_pkg::cmd_t                       cmd,
  input  logic                                cmd_empty,
  output logic                                cmd_pop,
  input  logic [bb3_pkg::OCC_W-1:0]           res_occ,
  output bb3_pkg::sum_t                       sum
);
  import bb3_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int NW    = WW + FH_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [FW_W-1:0]   fw_r;
  logic [FH_W-1:0]   fh_r;
  logic [WW-1:0]     w_eff;
  logic [FH_W-1:0]   h_eff;
  logic [NW-1:0]     total_r;
  logic [NW-1:0]     n_r, n_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [COL_W-1:0]  ocol_r, ocol_nxt;
  logic [FH_W-1:0]   orow_r, orow_nxt;
  logic              try_r, try_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [PX_W-1:0]   win_r [9];
  logic [PX_W-1:0]   win_nxt [9];
  sum_t              sum_r, sum_nxt;
  logic              sum_v_r;
  logic [PX_W-1:0]   top_px, mid_px;
  logic              old_we, new_we;
  logic              due;
  logic              col_wrap;
  logic              ocol_last, orow_last;
  logic [2:0]        col_ok, row_ok;
  logic [SUM_W-1:0]  acc_r, acc_g, acc_b;
  logic [CNT_W-1:0]  acc_n;
  logic              can_start;

  // effective frame size
  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    h_eff = (fh_r == '0) ? FH_W'(1) : fh_r;
  end

  // line stores: older row and newer row
  assign old_we = (state_r == ST_EXEC) && !cmd_r.is_flush;
  assign new_we = old_we;

  bb3_ram #(.WIDTH(PX_W), .DEPTH(MAX_WIDTH)) u_older (
    .clk     (clk),
    .wr_en   (old_we),
    .wr_addr (col_r),
    .wr_data (mid_px),
    .rd_addr (col_r),
    .rd_data (top_px)
  );

  bb3_ram #(.WIDTH(PX_W), .DEPTH(MAX_WIDTH)) u_newer (
    .clk     (clk),
    .wr_en   (new_we),
    .wr_addr (col_r),
    .wr_data (cmd_r.px),
    .rd_addr (col_r),
    .rd_data (mid_px)
  );

  // neighbourhood masks for the output position
  always_comb begin
    ocol_last = (WW'(ocol_r) + WW'(1)) >= w_eff;
    orow_last = ((FH_W + 1)'(orow_r) + (FH_W + 1)'(1)) >= (FH_W + 1)'(h_eff);
    col_ok    = {!ocol_last, 1'b1, (ocol_r != '0)};
    row_ok    = {!orow_last, 1'b1, (orow_r != '0)};
  end

  // masked window sums, column-major window
  always_comb begin
    acc_r = '0;
    acc_g = '0;
    acc_b = '0;
    for (int k = 0; k < 9; k++) begin
      if (col_ok[k / 3] && row_ok[k % 3]) begin
        acc_r = acc_r + SUM_W'(win_r[k][23:16]);
        acc_g = acc_g + SUM_W'(win_r[k][15:8]);
        acc_b = acc_b + SUM_W'(win_r[k][7:0]);
      end
    end
    acc_n = CNT_W'($countones(col_ok)) * CNT_W'($countones(row_ok));
  end

  assign due       = n_r >= (NW'(w_eff) + NW'(1));
  assign col_wrap  = (WW'(col_r) + WW'(1)) >= w_eff;
  assign can_start = (32'(res_occ) + 32'(sum_v_r)) < OUT_DEPTH;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    col_nxt   = col_r;
    ocol_nxt  = ocol_r;
    orow_nxt  = orow_r;
    try_nxt   = try_r;
    cmd_nxt   = cmd_r;
    sum_nxt   = sum_r;
    sum_nxt.valid = 1'b0;
    cmd_pop   = 1'b0;
    for (int k = 0; k < 9; k++) begin
      win_nxt[k] = win_r[k];
    end

    case (state_r)
      ST_IDLE: begin
        if (!cmd_empty && can_start) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          try_nxt = 1'b0;
          // pixels beyond the frame and early flushes are dropped
          if (cmd.is_flush ? (n_r >= total_r) : (n_r < total_r)) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        for (int k = 0; k < 6; k++) begin
          win_nxt[k] = win_r[k + 3];
        end
        win_nxt[6] = top_px;
        win_nxt[7] = mid_px;
        win_nxt[8] = cmd_r.px;
        n_nxt      = n_r + NW'(1);
        col_nxt    = col_wrap ? '0 : col_r + COL_W'(1);
        if (due) begin
          state_nxt = ST_EMIT;
        end else if (cmd_r.is_flush && !try_r) begin
          try_nxt   = 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        sum_nxt.valid     = 1'b1;
        sum_nxt.sum_r     = acc_r;
        sum_nxt.sum_g     = acc_g;
        sum_nxt.sum_b     = acc_b;
        sum_nxt.cnt       = acc_n;
        sum_nxt.frame_end = ocol_last && orow_last;
        if (ocol_last && orow_last) begin
          n_nxt    = '0;
          col_nxt  = '0;
          ocol_nxt = '0;
          orow_nxt = '0;
        end else if (ocol_last) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + FH_W'(1);
        end else begin
          ocol_nxt = ocol_r + COL_W'(1);
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write restarts the frame
    if (cfg_we) begin
      n_nxt    = '0;
      col_nxt  = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      fw_r          <= FW_RESET;
      fh_r          <= FH_RESET;
      n_r           <= '0;
      col_r         <= '0;
      ocol_r        <= '0;
      orow_r        <= '0;
      try_r         <= 1'b0;
      sum_v_r       <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      col_r       <= col_nxt;
      ocol_r      <= ocol_nxt;
      orow_r      <= orow_nxt;
      try_r       <= try_nxt;
      sum_v_r     <= sum_nxt.valid;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= win_nxt[k];
      end
      if (cfg_we && cfg_index == CFG_FRAME_WIDTH) begin
        fw_r <= cfg_data[FW_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_FRAME_HEIGHT) begin
        fh_r <= cfg_data[FH_W-1:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    total_r <= NW'(w_eff) * NW'(h_eff);
    sum_r   <= sum_nxt;
  end

  // sum beat with its reset valid bit
  always_comb begin
    sum       = sum_r;
    sum.valid = sum_v_r;
  end

endmodule

// ===== rtl/bb3_div.sv =====
module bb3_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bb3_pkg::sum_t      sum,
  output logic               res_push,
  output bb3_pkg::out_item_t res_item,
  output logic               busy
);
  import bb3_pkg::*;

  logic             yv_r;
  logic [SUM_W-1:0] yr_r, yg_r, yb_r;
  logic [CNT_W-1:0] cnt_r;
  logic             fe_r;

  // divide by a neighbour count of 1, 2, 3, 4, 6 or 9
  function automatic logic [CH_W-1:0] div_cnt(input logic [SUM_W-1:0] y,
                                              input logic [CNT_W-1:0] c);
    logic [SUM_W+15:0] prod;
    logic [CH_W-1:0]   q;
    prod = '0;
    q    = y[CH_W-1:0];
    case (c)
      4'd2: q = y[CH_W:1];
      4'd3: begin
        prod = (SUM_W + 16)'(y) * (SUM_W + 16)'(21846);
        q    = prod[23:16];
      end
      4'd4: q = y[CH_W+1:2];
      4'd6: begin
        prod = (SUM_W + 16)'(y[SUM_W-1:1]) * (SUM_W + 16)'(21846);
        q    = prod[23:16];
      end
      4'd9: begin
        prod = (SUM_W + 16)'(y) * (SUM_W + 16)'(7282);
        q    = prod[23:16];
      end
      default: q = y[CH_W-1:0];
    endcase
    return q;
  endfunction

  // half-up rounding: floor((2s+c)/(2c)) = floor((s + c/2) / c)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yv_r <= 1'b0;
    end else begin
      yv_r <= sum.valid;
    end
  end

  always_ff @(posedge clk) begin
    yr_r  <= sum.sum_r + SUM_W'(sum.cnt[CNT_W-1:1]);
    yg_r  <= sum.sum_g + SUM_W'(sum.cnt[CNT_W-1:1]);
    yb_r  <= sum.sum_b + SUM_W'(sum.cnt[CNT_W-1:1]);
    cnt_r <= sum.cnt;
    fe_r  <= sum.frame_end;
  end

  assign res_push           = yv_r;
  assign busy               = yv_r;
  assign res_item.out_red   = div_cnt(yr_r, cnt_r);
  assign res_item.out_green = div_cnt(yg_r, cnt_r);
  assign res_item.out_blue  = div_cnt(yb_r, cnt_r);
  assign res_item.frame_end = fe_r;

endmodule

// ===== rtl/box_blur_3x3_stream_unit.sv =====
// 3x3 box blur over an RGB raster stream. Each pixel becomes the half-up rounded
// per-channel mean of its in-frame neighbours; results lag by one row plus one
// pixel, and after the last pixel one flush beat per pending result releases the
// rest, the last one carrying frame_end. Pixels beyond the frame and flushes sent
// early are dropped. A small input queue decouples the port from a sequencer whose
// read, execute and emit states do the registered line-store read, the window
// update and the sum stage, emit only for a beat giving a result; a flush may shift
// twice. Results pass a rounding divider into a 4-beat output queue. Register
// writes restart the frame; the user makes them only while idle; no check is made.
module box_blur_3x3_stream_unit #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  bb3_pkg::in_item_t               in_item,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output bb3_pkg::out_item_t              out_item,
  input  logic                            cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bb3_pkg::*;

  cmd_t                           cmd;
  logic                           cmd_empty;
  logic                           cmd_pop;
  sum_t                           sum;
  logic                           res_push;
  out_item_t                      res_item;
  logic                           div_busy;
  logic                           res_full;
  logic [$clog2(OUT_DEPTH+1)-1:0] res_count;
  logic [OCC_W-1:0]               res_occ;

  bb3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  bb3_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_occ   (res_occ),
    .sum       (sum)
  );

  bb3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .sum      (sum),
    .res_push (res_push),
    .res_item (res_item),
    .busy     (div_busy)
  );

  // output beats waiting or on their way
  assign res_occ = OCC_W'(res_count) + OCC_W'(div_busy);

  bb3_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_item),
    .pop       (out_pop),
    .pop_data  (out_item),
    .full      (res_full),
    .empty     (out_empty),
    .count     (res_count)
  );

  // credit scheme keeps the output queue from overflowing
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("result pushed into full output queue");

  // sequencer only takes commands that are there
  a_no_cmd_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd_pop && cmd_empty))
    else $error("command popped from empty queue");

  // a result appears only after the divider delivered it
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_empty) |-> $past(res_push))
    else $error("output became valid without a push");

  // divider pushes each sum beat as a result in the next cycle
  a_div_follows_sum: assert property (@(posedge clk) disable iff (!rst_n)
    sum.valid |=> res_push)
    else $error("sum lost before rounding");

endmodule

// ===== tb/sv/box_blur_3x3_stream_unit_tb.sv =====
module box_blur_3x3_stream_unit_tb;
  import bb3_pkg::*;

  localparam int ROW_MAX    = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 64;
  localparam int HOLD_LONG  = 400;

  typedef enum int {ROW_PIXEL, ROW_FLUSH, ROW_SET_W, ROW_SET_H} row_op_t;

  typedef struct {
    row_op_t   op;
    int        arg;
    logic [23:0] px;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_item_t in_item = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_blur_3x3_stream_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // blur model state
  logic [FW_W-1:0] blur_w_reg;
  logic [FH_W-1:0] blur_h_reg;
  logic [23:0] older_line [ROW_MAX];
  logic [23:0] newer_line [ROW_MAX];
  logic [23:0] win [9];
  int unsigned in_col, in_row;
  longint unsigned emitted;

  out_item_t blurred_q [$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int frames_done = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report(string what, out_item_t got, out_item_t want);
    $display("error at beat %0d: %s got %h want %h", beats_out, what, got, want);
    errors++;
  endtask

  function automatic int unsigned eff_w();
    if (blur_w_reg == 0) return 1;
    if (blur_w_reg > ROW_MAX) return ROW_MAX;
    return blur_w_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (blur_h_reg == 0) ? 1 : blur_h_reg;
  endfunction

  function automatic void blur_reset();
    blur_w_reg = FW_RESET;
    blur_h_reg = FH_RESET;
    foreach (older_line[i]) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    in_col = 0;
    in_row = 0;
    emitted = 0;
  endfunction

  // shift one slot into the window; true once an output is due
  function automatic bit shift_slot(bit real_px, logic [23:0] px, int unsigned w);
    logic [23:0] top, mid;
    longint unsigned n;
    n = longint'(in_row) * w + in_col;
    top = older_line[in_col];
    mid = newer_line[in_col];
    if (real_px) begin
      older_line[in_col] = mid;
      newer_line[in_col] = px;
    end
    for (int k = 0; k < 6; k++) win[k] = win[k+3];
    win[6] = top;
    win[7] = mid;
    win[8] = px;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    return n >= w + 1;
  endfunction

  function automatic out_item_t blur_pixel(int unsigned w, int unsigned h);
    out_item_t o;
    longint orow, ocol, c, r;
    int unsigned sr, sg, sb, cnt;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    orow = emitted / w;
    ocol = emitted % w;
    for (int cp = 0; cp < 3; cp++) begin
      c = ocol + cp - 1;
      if (c < 0 || c >= w) continue;
      for (int rp = 0; rp < 3; rp++) begin
        r = orow + rp - 1;
        if (r < 0 || r >= h) continue;
        sr += win[cp*3+rp][23:16];
        sg += win[cp*3+rp][15:8];
        sb += win[cp*3+rp][7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    o.out_red   = 8'((2*sr + cnt) / (2*cnt));
    o.out_green = 8'((2*sg + cnt) / (2*cnt));
    o.out_blue  = 8'((2*sb + cnt) / (2*cnt));
    if (emitted + 1 >= longint'(w) * h) begin
      o.frame_end = 1'b1;
      in_col = 0;
      in_row = 0;
      emitted = 0;
    end else begin
      o.frame_end = 1'b0;
      emitted++;
    end
    return o;
  endfunction

  // advance the model by one accepted beat
  function automatic bit blur_step(in_item_t it, output out_item_t o);
    int unsigned w, h;
    longint unsigned n;
    w = eff_w();
    h = eff_h();
    n = longint'(in_row) * w + in_col;
    o = '0;
    if (it.kind == KIND_PIXEL) begin
      if (n >= longint'(w) * h) return 1'b0;
      if (shift_slot(1'b1, {it.in_red, it.in_green, it.in_blue}, w)) begin
        o = blur_pixel(w, h);
        return 1'b1;
      end
      return 1'b0;
    end
    if (n < longint'(w) * h) return 1'b0;
    for (int t = 0; t < 2; t++) begin
      if (shift_slot(1'b0, '0, w)) begin
        o = blur_pixel(w, h);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // send one beat with optional idle burst; returns whether it gave a result
  task automatic send_beat(in_item_t it, bit typed, out_item_t want, output out_item_t got,
                           output bit gave);
    bit ok;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      ok = !in_full;
      @(posedge clk);
    end while (!ok);
    beats_in++;
    gave = blur_step(it, got);
    if (gave) begin
      blurred_q.push_back(typed ? want : got);
      if (got.frame_end) frames_done++;
    end
  endtask

  task automatic go_idle();
    in_push <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    go_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) blur_w_reg = FW_W'(value);
    else blur_h_reg = FH_W'(value);
    in_col = 0;
    in_row = 0;
    emitted = 0;
  endtask

  function automatic in_item_t rand_pixel();
    in_item_t it;
    it.kind = KIND_PIXEL;
    it.in_red = 8'($urandom);
    it.in_green = 8'($urandom);
    it.in_blue = 8'($urandom);
    return it;
  endfunction

  function automatic in_item_t flush_beat();
    in_item_t it;
    it = '0;
    it.kind = KIND_FLUSH;
    it.in_red = 8'($urandom);
    it.in_green = 8'($urandom);
    it.in_blue = 8'($urandom);
    return it;
  endfunction

  function automatic stim_row_t mk(row_op_t op, int arg, logic [23:0] px, bit typed,
                                   out_item_t want);
    stim_row_t s;
    s.op = op;
    s.arg = arg;
    s.px = px;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  // result side: random stalls and the long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (out_pop && !out_empty) begin
        beats_out++;
        if (blurred_q.size() == 0) begin
          report("unexpected beat", out_item, '0);
        end else begin
          out_item_t want;
          want = blurred_q.pop_front();
          if (out_item.out_red !== want.out_red) report("out_red", out_item, want);
          if (out_item.out_green !== want.out_green) report("out_green", out_item, want);
          if (out_item.out_blue !== want.out_blue) report("out_blue", out_item, want);
          if (out_item.frame_end !== want.frame_end) report("frame_end", out_item, want);
        end
      end
      @(posedge clk);
      if (long_hold) begin
        out_pop <= 1'b0;
        repeat (HOLD_LONG) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 14) - 1) @(posedge clk);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    int still;
    still = 0;
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n) still = 0;
      else still++;
      if (still >= IDLE_LIMIT) begin
        $display("box_blur_3x3_stream_unit: mismatch");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    stim_row_t rows [$];
    out_item_t got, none;
    bit gave;
    in_item_t it;
    int w, h, npix;
    none = '0;
    blur_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single pixel frames, early flush, late pixel, then a 2x2 frame
    rows.push_back(mk(ROW_SET_W, 1, '0, 0, none));
    rows.push_back(mk(ROW_SET_H, 1, '0, 0, none));
    rows.push_back(mk(ROW_FLUSH, 0, '0, 0, none));
    rows.push_back(mk(ROW_PIXEL, 0, 24'hffffff, 0, none));
    rows.push_back(mk(ROW_PIXEL, 0, 24'h000000, 0, none));
    rows.push_back(mk(ROW_FLUSH, 0, '0, 1, '{8'hff, 8'hff, 8'hff, 1'b1}));
    rows.push_back(mk(ROW_PIXEL, 0, 24'h123456, 0, none));
    rows.push_back(mk(ROW_FLUSH, 0, '0, 1, '{8'h12, 8'h34, 8'h56, 1'b1}));
    rows.push_back(mk(ROW_SET_W, 0, '0, 0, none));
    rows.push_back(mk(ROW_SET_H, 0, '0, 0, none));
    rows.push_back(mk(ROW_PIXEL, 0, 24'h00ff00, 0, none));
    rows.push_back(mk(ROW_FLUSH, 0, '0, 1, '{8'h00, 8'hff, 8'h00, 1'b1}));
    rows.push_back(mk(ROW_SET_W, 2, '0, 0, none));
    rows.push_back(mk(ROW_SET_H, 2, '0, 0, none));
    rows.push_back(mk(ROW_PIXEL, 0, 24'hffffff, 0, none));
    rows.push_back(mk(ROW_PIXEL, 0, 24'h000000, 0, none));
    rows.push_back(mk(ROW_PIXEL, 0, 24'hff00ff, 0, none));
    rows.push_back(mk(ROW_PIXEL, 0, 24'h01fe80, 0, none));
    rows.push_back(mk(ROW_FLUSH, 0, '0, 0, none));
    rows.push_back(mk(ROW_FLUSH, 0, '0, 0, none));
    rows.push_back(mk(ROW_FLUSH, 0, '0, 0, none));
    foreach (rows[i]) begin
      case (rows[i].op)
        ROW_SET_W: write_reg(CFG_FRAME_WIDTH, rows[i].arg);
        ROW_SET_H: write_reg(CFG_FRAME_HEIGHT, rows[i].arg);
        default: begin
          it = (rows[i].op == ROW_FLUSH) ? flush_beat() : rand_pixel();
          if (rows[i].op == ROW_PIXEL) {it.in_red, it.in_green, it.in_blue} = rows[i].px;
          send_beat(it, rows[i].typed, rows[i].want, got, gave);
        end
      endcase
    end

    // widest row and tallest frame, abandoned part way with the output held off
    write_reg(CFG_FRAME_WIDTH, 2047);
    write_reg(CFG_FRAME_HEIGHT, 65535);
    long_hold = 1'b1;
    for (int i = 0; i < 1060; i++) send_beat(rand_pixel(), 0, none, got, gave);
    write_reg(CFG_FRAME_WIDTH, 1024);

    // random frames, mostly small, some abandoned, with stray beats
    while (beats_in < 1900) begin
      if (beats_in > 1700) quiet = 1'b1;
      w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
      h = $urandom_range(0, 6);
      write_reg(CFG_FRAME_WIDTH, w);
      write_reg(CFG_FRAME_HEIGHT, h);
      npix = eff_w() * eff_h();
      if ($urandom_range(0, 9) == 0) npix = $urandom_range(0, npix);
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 19) == 0) send_beat(flush_beat(), 0, none, got, gave);
        send_beat(rand_pixel(), 0, none, got, gave);
      end
      if (npix == eff_w() * eff_h()) begin
        gave = 1'b0;
        got = '0;
        while (!(gave && got.frame_end)) begin
          if ($urandom_range(0, 19) == 0) send_beat(rand_pixel(), 0, none, got, gave);
          else send_beat(flush_beat(), 0, none, got, gave);
        end
      end
    end
    go_idle();

    $display("covered %0d input beats, %0d result beats, %0d complete frames",
             beats_in, beats_out, frames_done);
    $display("widths 0 to 2047 and heights 0 to 65535, with early flushes and late pixels");
    if (errors == 0) begin
      $display("box_blur_3x3_stream_unit: match");
    end else begin
      $display("box_blur_3x3_stream_unit: mismatch");
    end
    $finish;
  end

endmodule
